/* sv/rmq_pkg.sv */
// Shared types, widths and helpers for the rotation-matrix-to-quaternion unit.
`default_nettype none
package rmq_pkg;

  // Number format: signed fixed point with two integer bits.
  localparam int DATA_WIDTH = 16;
  localparam int FRAC       = DATA_WIDTH - 2;

  // Signed width that holds any trace or radicand.
  localparam int EW  = DATA_WIDTH + 2;
  // Unsigned width of a positive radicand.
  localparam int RW  = DATA_WIDTH + 1;
  // Width of the radicand scaled by 2^FRAC.
  localparam int VW  = RW + FRAC;
  // Width of the integer square root.
  localparam int SQW = (VW + 1) / 2;
  // Width of the trial value in the square root recurrence.
  localparam int TW  = 2 * SQW + 1;
  // Width of the magnitude of an off-diagonal sum or difference.
  localparam int MW  = DATA_WIDTH + 1;
  // Width of the divider numerator (magnitude scaled, plus rounding term).
  localparam int NW  = MW + FRAC;
  // Width of the divisor 2R.
  localparam int DVW = SQW + 1;
  // Quotient width; the smallest root bounds the largest quotient.
  localparam int QW  = NW - FRAC / 2 - 1;
  // Width of the shifted divisor used in the compare.
  localparam int CW  = DVW + QW;
  // Number of divided components per word.
  localparam int LANES = 3;

  // Branch codes: which component comes from the root directly.
  localparam logic [1:0] SEL_W = 2'd0;
  localparam logic [1:0] SEL_X = 2'd1;
  localparam logic [1:0] SEL_Y = 2'd2;
  localparam logic [1:0] SEL_Z = 2'd3;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] m00;
    logic signed [DATA_WIDTH-1:0] m01;
    logic signed [DATA_WIDTH-1:0] m02;
    logic signed [DATA_WIDTH-1:0] m10;
    logic signed [DATA_WIDTH-1:0] m11;
    logic signed [DATA_WIDTH-1:0] m12;
    logic signed [DATA_WIDTH-1:0] m20;
    logic signed [DATA_WIDTH-1:0] m21;
    logic signed [DATA_WIDTH-1:0] m22;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] qx;
    logic signed [DATA_WIDTH-1:0] qy;
    logic signed [DATA_WIDTH-1:0] qz;
    logic signed [DATA_WIDTH-1:0] qw;
    logic                         degenerate;
  } out_word_t;

  // Per-word side information that rides along the pipeline.
  typedef struct packed {
    logic [1:0]                  sel;
    logic                        degen;
    logic [LANES-1:0]            neg;
    logic [LANES-1:0][MW-1:0]    mag;
  } meta_t;

  typedef struct packed {
    meta_t          meta;
    logic [VW-1:0]  v;
  } front_t;

  typedef struct packed {
    meta_t           meta;
    logic [VW-1:0]   rem;
    logic [SQW-1:0]  root;
  } sqrt_t;

  typedef struct packed {
    logic [1:0]               sel;
    logic                     degen;
    logic [LANES-1:0]         neg;
    logic [SQW-1:0]           root;
    logic [DVW-1:0]           dvs;
    logic [LANES-1:0][NW-1:0] rem;
    logic [LANES-1:0][QW-1:0] quo;
  } div_t;

  // Apply the sign to a quotient magnitude and clamp to the output range.
  function automatic logic [DATA_WIDTH-1:0] sat_lane(input logic neg,
                                                     input logic [QW-1:0] q);
    logic [QW-1:0] pmax;
    logic [QW-1:0] nmax;
    logic [QW-1:0] negq;
    pmax = QW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
    nmax = QW'(64'd1 << (DATA_WIDTH - 1));
    negq = QW'(0) - q;
    if (!neg) begin
      sat_lane = (q > pmax) ? pmax[DATA_WIDTH-1:0] : q[DATA_WIDTH-1:0];
    end else begin
      sat_lane = (q > nmax) ? nmax[DATA_WIDTH-1:0] : negq[DATA_WIDTH-1:0];
    end
  endfunction

  // Half of the root, rounded half up, clamped to the positive limit.
  function automatic logic [DATA_WIDTH-1:0] big_comp(input logic [SQW-1:0] root);
    logic [SQW:0] half;
    logic [SQW:0] pmax;
    half = ({1'b0, root} + (SQW+1)'(1)) >> 1;
    pmax = (SQW+1)'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
    big_comp = (half > pmax) ? pmax[DATA_WIDTH-1:0] : half[DATA_WIDTH-1:0];
  endfunction

endpackage
`default_nettype wire

/* sv/rotation_matrix_to_quaternion_unit.sv */
// Top level: rotation matrix to unit quaternion, fully pipelined.
//
//   Channel | Ports                          | Word
//   --------+--------------------------------+---------------------------------
//   input   | in_valid, in_stall, in_word    | m00..m22, signed Q2.14
//   result  | out_valid, out_stall, out_word | qx, qy, qz, qw, degenerate
//
// One word enters per cycle while in_stall is low. A word passes one front stage,
// one square root stage per root bit, one divider prep stage, one divider
// stage per quotient bit, and the output register.
// Reset clears only the valid bits of every stage.
// Each stage holds while it is full and the one after it is held, so a stall at the
// output fills the bubbles before it reaches in_stall; no word is lost or doubled.
`default_nettype none
module rotation_matrix_to_quaternion_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rmq_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rmq_pkg::out_word_t      out_word
);
  import rmq_pkg::*;

  logic      fr_valid, fr_adv, sq_valid, sq_adv, dv_valid, dv_adv, in_adv, o_adv;
  front_t    fr_data;
  sqrt_t     sq_data;
  div_t      dv_data;
  logic      out_valid_r;
  out_word_t out_word_r;
  out_word_t out_nxt;
  logic [DATA_WIDTH-1:0] big;
  logic [DATA_WIDTH-1:0] lq [LANES];

  rmq_front u_front (
    .clk, .rst_n,
    .up_valid (in_valid), .up_adv (in_adv), .up_word (in_word),
    .dn_valid (fr_valid), .dn_adv (fr_adv), .dn_data (fr_data)
  );

  rmq_sqrt u_sqrt (
    .clk, .rst_n,
    .up_valid (fr_valid), .up_adv (fr_adv), .up_data (fr_data),
    .dn_valid (sq_valid), .dn_adv (sq_adv), .dn_data (sq_data)
  );

  rmq_div u_div (
    .clk, .rst_n,
    .up_valid (sq_valid), .up_adv (sq_adv), .up_data (sq_data),
    .dn_valid (dv_valid), .dn_adv (dv_adv), .dn_data (dv_data)
  );

  assign in_stall = !in_adv;

  // Sign, clamp and route the lanes back to x, y, z, w.
  always_comb begin
    big = big_comp(dv_data.root);
    for (int l = 0; l < LANES; l++) begin
      lq[l] = sat_lane(dv_data.neg[l], dv_data.quo[l]);
    end
    out_nxt.degenerate = 1'b0;
    case (dv_data.sel)
      SEL_W: begin
        out_nxt.qx = lq[0]; out_nxt.qy = lq[1]; out_nxt.qz = lq[2]; out_nxt.qw = big;
      end
      SEL_X: begin
        out_nxt.qx = big; out_nxt.qy = lq[1]; out_nxt.qz = lq[2]; out_nxt.qw = lq[0];
      end
      SEL_Y: begin
        out_nxt.qx = lq[1]; out_nxt.qy = big; out_nxt.qz = lq[2]; out_nxt.qw = lq[0];
      end
      default: begin
        out_nxt.qx = lq[1]; out_nxt.qy = lq[2]; out_nxt.qz = big; out_nxt.qw = lq[0];
      end
    endcase
    if (dv_data.degen) begin
      out_nxt = '0;
      out_nxt.degenerate = 1'b1;
    end
  end

  assign o_adv  = !out_valid_r || !out_stall;
  assign dv_adv = o_adv;

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (o_adv) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_adv && dv_valid) begin
      out_word_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

/* sv/rmq_front.sv */
// Front stage: branch choice, radicand and off-diagonal terms.
`default_nettype none
module rmq_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              up_valid,
  output logic                   up_adv,
  input  wire rmq_pkg::in_word_t up_word,
  output logic                   dn_valid,
  input  wire logic              dn_adv,
  output rmq_pkg::front_t        dn_data
);
  import rmq_pkg::*;

  logic            vld_r;
  front_t          data_r;
  front_t          data_nxt;

  logic signed [EW-1:0] a00, a11, a22, one, tr, r;
  logic signed [MW-1:0] d_wx, d_wy, d_wz, s_xy, s_xz, s_yz;
  logic signed [MW-1:0] lane_d [LANES];
  logic [1:0]           sel;

  // Widen the diagonal and form the trace.
  always_comb begin
    a00 = EW'(up_word.m00);
    a11 = EW'(up_word.m11);
    a22 = EW'(up_word.m22);
    one = EW'(1) <<< FRAC;
    tr  = a00 + a11 + a22;
  end

  // Pick the branch and its radicand; comparisons are strict.
  always_comb begin
    if (tr > 0) begin
      sel = SEL_W;
      r   = tr + one;
    end else if (a00 > a11 && a00 > a22) begin
      sel = SEL_X;
      r   = one + a00 - a11 - a22;
    end else if (a11 > a22) begin
      sel = SEL_Y;
      r   = one + a11 - a00 - a22;
    end else begin
      sel = SEL_Z;
      r   = one + a22 - a00 - a11;
    end
  end

  // Off-diagonal sums and differences at full precision.
  always_comb begin
    d_wx = MW'(up_word.m21) - MW'(up_word.m12);
    d_wy = MW'(up_word.m02) - MW'(up_word.m20);
    d_wz = MW'(up_word.m10) - MW'(up_word.m01);
    s_xy = MW'(up_word.m01) + MW'(up_word.m10);
    s_xz = MW'(up_word.m02) + MW'(up_word.m20);
    s_yz = MW'(up_word.m12) + MW'(up_word.m21);
  end

  // Lanes hold the three divided components: x, y, z for the w branch, else w, then the other two in x, y, z order.
  always_comb begin
    case (sel)
      SEL_W: begin
        lane_d[0] = d_wx; lane_d[1] = d_wy; lane_d[2] = d_wz;
      end
      SEL_X: begin
        lane_d[0] = d_wx; lane_d[1] = s_xy; lane_d[2] = s_xz;
      end
      SEL_Y: begin
        lane_d[0] = d_wy; lane_d[1] = s_xy; lane_d[2] = s_yz;
      end
      default: begin
        lane_d[0] = d_wz; lane_d[1] = s_xz; lane_d[2] = s_yz;
      end
    endcase
  end

  // Assemble the next word.
  always_comb begin
    data_nxt.meta.sel   = sel;
    data_nxt.meta.degen = r[EW-1] || (r == '0);
    for (int l = 0; l < LANES; l++) begin
      data_nxt.meta.neg[l] = lane_d[l][MW-1];
      data_nxt.meta.mag[l] = lane_d[l][MW-1] ? MW'(-lane_d[l]) : MW'(lane_d[l]);
    end
    data_nxt.v = {r[RW-1:0], {FRAC{1'b0}}};
  end

  assign up_adv = !vld_r || dn_adv;

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_adv) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_adv && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule
`default_nettype wire

/* sv/rmq_sqrt.sv */
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module rmq_sqrt (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             up_valid,
  output logic                  up_adv,
  input  wire rmq_pkg::front_t  up_data,
  output logic                  dn_valid,
  input  wire logic             dn_adv,
  output rmq_pkg::sqrt_t        dn_data
);
  import rmq_pkg::*;

  sqrt_t st_in  [SQW+1];
  logic  vl_in  [SQW+1];
  logic  adv    [SQW+1];
  sqrt_t st_r   [SQW];
  logic  vld_r  [SQW];

  // Seed: full remainder, empty root.
  assign st_in[0].meta = up_data.meta;
  assign st_in[0].rem  = up_data.v;
  assign st_in[0].root = '0;
  assign vl_in[0]      = up_valid;
  assign adv[SQW]      = dn_adv;

  for (genvar i = 0; i < SQW; i++) begin : g_stage
    localparam int K = SQW - 1 - i;
    logic [TW-1:0] trial;
    sqrt_t         st_nxt;

    // Try setting root bit K: the square grows by root*2^(K+1) + 2^(2K).
    always_comb begin
      trial  = (TW'(st_in[i].root) << (K + 1)) | (TW'(1) << (2 * K));
      st_nxt = st_in[i];
      if (TW'(st_in[i].rem) >= trial) begin
        st_nxt.rem  = st_in[i].rem - VW'(trial);
        st_nxt.root = st_in[i].root | (SQW'(1) << K);
      end
    end

    assign adv[i] = !vld_r[i] || adv[i+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (adv[i]) begin
        vld_r[i] <= vl_in[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[i] && vl_in[i]) begin
        st_r[i] <= st_nxt;
      end
    end

    assign st_in[i+1] = st_r[i];
    assign vl_in[i+1] = vld_r[i];
  end

  assign up_adv   = adv[0];
  assign dn_valid = vl_in[SQW];
  assign dn_data  = st_in[SQW];

endmodule
`default_nettype wire

/* sv/rmq_div.sv */
// Pipelined three-lane restoring divider, one quotient bit per stage.
`default_nettype none
module rmq_div (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            up_valid,
  output logic                 up_adv,
  input  wire rmq_pkg::sqrt_t  up_data,
  output logic                 dn_valid,
  input  wire logic            dn_adv,
  output rmq_pkg::div_t        dn_data
);
  import rmq_pkg::*;

  localparam int NS = QW + 1;

  div_t  st_in [NS+1];
  logic  vl_in [NS+1];
  logic  adv   [NS+1];
  div_t  st_r  [NS];
  logic  vld_r [NS];
  div_t  prep_nxt;

  // Prep: divisor 2R and numerator |d|*2^FRAC + R for round half away.
  always_comb begin
    prep_nxt.sel   = up_data.meta.sel;
    prep_nxt.degen = up_data.meta.degen;
    prep_nxt.neg   = up_data.meta.neg;
    prep_nxt.root  = up_data.root;
    prep_nxt.dvs   = {up_data.root, 1'b0};
    prep_nxt.quo   = '0;
    for (int l = 0; l < LANES; l++) begin
      prep_nxt.rem[l] = {up_data.meta.mag[l], {FRAC{1'b0}}} + NW'(up_data.root);
    end
  end

  assign st_in[0] = prep_nxt;
  assign vl_in[0] = up_valid;
  assign adv[NS]  = dn_adv;

  for (genvar j = 0; j < NS; j++) begin : g_stage
    div_t st_nxt;

    if (j == 0) begin : g_prep
      assign st_nxt = st_in[0];
    end else begin : g_bit
      localparam int B = QW - j;
      logic [CW-1:0] trial;

      // Subtract the shifted divisor where it fits and set quotient bit B.
      always_comb begin
        trial  = CW'(st_in[j].dvs) << B;
        st_nxt = st_in[j];
        for (int l = 0; l < LANES; l++) begin
          if (CW'(st_in[j].rem[l]) >= trial) begin
            st_nxt.rem[l]    = st_in[j].rem[l] - NW'(trial);
            st_nxt.quo[l][B] = 1'b1;
          end
        end
      end
    end

    assign adv[j] = !vld_r[j] || adv[j+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (adv[j]) begin
        vld_r[j] <= vl_in[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[j] && vl_in[j]) begin
        st_r[j] <= st_nxt;
      end
    end

    assign st_in[j+1] = st_r[j];
    assign vl_in[j+1] = vld_r[j];
  end

  assign up_adv   = adv[0];
  assign dn_valid = vl_in[NS];
  assign dn_data  = st_in[NS];

endmodule
`default_nettype wire
